/* src/aes128_block_cipher_defines.svh */
// assertion macros shared by the checker
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/aes_pkg.sv */
package aes_pkg;

    typedef struct packed {
        logic        req_type;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } aes_out_t;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam int         NUM_ROUNDS   = 10;

    // datapath command from the controller
    typedef struct packed {
        logic       load;
        logic       round;
        logic       last;
        logic       dec;
    } aes_cmd_t;

    // status back to the controller
    typedef struct packed {
        logic       key_ready;
    } aes_stat_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r = r ^ p;
            p = xtime(p);
        end
        gf_mul = r;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h01;
        p = a;
        for (int i = 0; i < 8; i++)
        begin
            if (i != 0)
                r = gf_mul(r, p);
            p = gf_mul(p, p);
        end
        gf_inv = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        rotl8 = (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] a);
        logic [7:0] b;
        b = gf_inv(a);
        sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox_calc(input logic [7:0] a);
        inv_sbox_calc = gf_inv(rotl8(a, 1) ^ rotl8(a, 3) ^ rotl8(a, 6) ^ 8'h05);
    endfunction

    // constant tables built at elaboration
    typedef logic [7:0] sbox_tab_t [256];

    function automatic sbox_tab_t make_sbox(input logic inv);
        sbox_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
        end
        make_sbox = t;
    endfunction

    localparam sbox_tab_t SBOX     = make_sbox(1'b0);
    localparam sbox_tab_t INV_SBOX = make_sbox(1'b1);

endpackage

/* src/aes_ctrl.sv */
module aes_ctrl
    import aes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  logic      in_dec,
    input  aes_stat_t stat,
    output aes_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t     state_reg;
    logic [3:0] round_reg;
    logic       dec_reg;

    assign in_stall  = !((state_reg == ST_IDLE) || (state_reg == ST_DONE && !out_stall))
                       || !stat.key_ready;
    assign out_valid = (state_reg == ST_DONE);

    always_comb
    begin
        cmd       = '0;
        cmd.dec   = dec_reg;
        cmd.load  = in_valid && !in_stall;
        if (cmd.load)
            cmd.dec = in_dec;
        cmd.round = (state_reg == ST_RUN);
        cmd.last  = (round_reg == 4'(NUM_ROUNDS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            dec_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE, ST_DONE:
                begin
                    if (cmd.load)
                    begin
                        state_reg <= ST_RUN;
                        round_reg <= 4'd1;
                        dec_reg   <= in_dec;
                    end
                    else if (state_reg == ST_DONE && !out_stall)
                        state_reg <= ST_IDLE;
                end
                ST_RUN:
                begin
                    if (round_reg == 4'(NUM_ROUNDS))
                        state_reg <= ST_DONE;
                    round_reg <= round_reg + 4'd1;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* src/aes_dp.sv */
module aes_dp
    import aes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [127:0] key,
    input  aes_in_t      din,
    input  aes_cmd_t     cmd,
    output aes_stat_t    stat,
    output aes_out_t     dout
);

    // key schedule: rk_reg walks round keys, forward or backward; last_key_reg
    // caches round 10 key for decryption, redone when the cipher key changes
    logic [127:0] state_reg;
    logic [127:0] rk_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] key_seen_reg;
    logic [127:0] last_key_reg;
    logic [3:0]   prep_reg;
    logic         prep_busy_reg;
    logic [127:0] prep_key_reg;
    logic [7:0]   prep_rcon_reg;

    function automatic logic [127:0] next_rk(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t;
        logic [127:0] n;
        t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
             SBOX[k[111:104]] ^ rc};
        n[31:0]   = k[31:0] ^ t;
        n[63:32]  = k[63:32] ^ n[31:0];
        n[95:64]  = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        next_rk = n;
    endfunction

    function automatic logic [127:0] prev_rk(input logic [127:0] n, input logic [7:0] rc);
        logic [31:0] t;
        logic [127:0] k;
        k[127:96] = n[127:96] ^ n[95:64];
        k[95:64]  = n[95:64] ^ n[63:32];
        k[63:32]  = n[63:32] ^ n[31:0];
        t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
             SBOX[k[111:104]] ^ rc};
        k[31:0]   = n[31:0] ^ t;
        prev_rk = k;
    endfunction

    function automatic logic [7:0] inv_xtime(input logic [7:0] a);
        inv_xtime = {1'b0, a[7:1]} ^ (a[0] ? 8'h8d : 8'h00);
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] r;
        for (int c = 0; c < 4; c++)
            for (int rr = 0; rr < 4; rr++)
                t[rr + 4 * c] = SBOX[s[8 * (rr + 4 * ((c + rr) % 4)) +: 8]];
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
            if (!last)
            begin
                t[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                t[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                t[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                t[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++)
            r[8 * i +: 8] = t[i];
        enc_round = r;
    endfunction

    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] r;
        for (int c = 0; c < 4; c++)
            for (int rr = 0; rr < 4; rr++)
                t[rr + 4 * ((c + rr) % 4)] = INV_SBOX[s[8 * (rr + 4 * c) +: 8]];
        for (int i = 0; i < 16; i++)
            t[i] = t[i] ^ k[8 * i +: 8];
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
            if (!last)
            begin
                t[4 * c]     = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                               ^ gf_mul(a3, 8'd9);
                t[4 * c + 1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                               ^ gf_mul(a3, 8'd13);
                t[4 * c + 2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                               ^ gf_mul(a3, 8'd11);
                t[4 * c + 3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                               ^ gf_mul(a3, 8'd14);
            end
        end
        for (int i = 0; i < 16; i++)
            r[8 * i +: 8] = t[i];
        dec_round = r;
    endfunction

    logic [127:0] blk;
    logic [127:0] rk_next;
    logic [127:0] rk_prev;
    logic [7:0]   rcon_prev;

    assign blk       = {din.block_high, din.block_low};
    assign rk_next   = next_rk(rk_reg, rcon_reg);
    assign rcon_prev = inv_xtime(rcon_reg);
    assign rk_prev   = prev_rk(rk_reg, rcon_prev);

    assign stat.key_ready = !prep_busy_reg && (key_seen_reg == key);
    assign dout.out_low   = state_reg[63:0];
    assign dout.out_high  = state_reg[127:64];

    // key preparation: ten forward schedule steps to reach the last round key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_busy_reg <= 1'b0;
            prep_reg      <= '0;
            key_seen_reg  <= '1;
            prep_key_reg  <= '0;
            prep_rcon_reg <= '0;
            last_key_reg  <= '0;
        end
        else if (prep_busy_reg)
        begin
            prep_key_reg  <= next_rk(prep_key_reg, prep_rcon_reg);
            prep_rcon_reg <= xtime(prep_rcon_reg);
            prep_reg      <= prep_reg + 4'd1;
            if (prep_reg == 4'(NUM_ROUNDS - 1))
            begin
                prep_busy_reg <= 1'b0;
                last_key_reg  <= next_rk(prep_key_reg, prep_rcon_reg);
            end
        end
        else if (key_seen_reg != key)
        begin
            key_seen_reg  <= key;
            prep_key_reg  <= key;
            prep_rcon_reg <= 8'h01;
            prep_reg      <= '0;
            prep_busy_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (cmd.dec)
            begin
                state_reg <= blk ^ last_key_reg;
                rk_reg    <= last_key_reg;
                rcon_reg  <= 8'h6c;
            end
            else
            begin
                state_reg <= blk ^ key;
                rk_reg    <= next_rk(key, 8'h01);
                rcon_reg  <= 8'h02;
            end
        end
        else if (cmd.round)
        begin
            if (cmd.dec)
            begin
                state_reg <= dec_round(state_reg, rk_prev, cmd.last);
                rk_reg    <= rk_prev;
                rcon_reg  <= rcon_prev;
            end
            else
            begin
                state_reg <= enc_round(state_reg, cmd.last) ^ rk_reg;
                rk_reg    <= rk_next;
                rcon_reg  <= xtime(rcon_reg);
            end
        end
    end

endmodule

/* src/aes128_block_cipher.sv */
// aes-128 block cipher, one block at a time
// input channel: in_valid/in_stall with in_data (req_type, block_low, block_high);
//   req_type 0 encrypts, 1 decrypts
// output channel: out_valid/out_stall with out_data (out_low, out_high)
// key: written through the apb port, key_low at 0x0 and key_high at 0x8
// an item is accepted, then the shared round unit runs ten rounds, one a cycle;
//   the initial key addition happens as the item is loaded
// a new item can be taken in the cycle its predecessor's result is taken,
//   but not while the rounds of an earlier item are still running
// after a key write (and after reset) the key schedule is run forward once,
//   10 steps, to get the last round key; in_stall is held meanwhile
// reset clears the controller and both key registers to zero
// a stalled result holds on out_data and blocks the next item
module aes128_block_cipher
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  aes_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output aes_out_t    out_data
);

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic [1:0]  reg_idx;
    aes_cmd_t    cmd;
    aes_stat_t   stat;

    assign pready  = 1'b1;
    assign reg_idx = {1'b0, paddr[3]};

    always_comb
    begin
        prdata = '0;
        if (paddr[2:0] == 3'd0)
        begin
            case (reg_idx)
                REG_KEY_LOW:  prdata = key_low_reg;
                REG_KEY_HIGH: prdata = key_high_reg;
                default:      prdata = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2:0] == 3'd0)
        begin
            case (reg_idx)
                REG_KEY_LOW:  key_low_reg  <= pwdata;
                REG_KEY_HIGH: key_high_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    aes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .in_dec    (in_data.req_type),
        .stat      (stat),
        .cmd       (cmd)
    );

    aes_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .key   ({key_high_reg, key_low_reg}),
        .din   (in_data),
        .cmd   (cmd),
        .stat  (stat),
        .dout  (out_data)
    );

endmodule

/* src/aes_checker.sv */
`include "aes128_block_cipher_defines.svh"

module aes_checker
    import aes_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input aes_out_t out_data
);

    `AES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
    `AES_ASSERT_NEXT(a_no_result_after_accept, clk, rst_n, in_valid && !in_stall, !out_valid, "result too early after accept")
    `AES_ASSERT_IMP(a_no_accept_while_busy, clk, rst_n, out_valid && out_stall, in_stall, "item accepted while result waits")

endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
